### rtl/core/rti_pkg.sv
// Shared widths, payload types and constants of the ray/triangle intersection core.
// No dependencies; compiled first.
`default_nettype none
package rti_pkg;

    localparam int CoordBits    = 16;
    localparam int FracBits     = 8;
    localparam int NormBits     = 16;
    localparam int VecBits      = 3 * CoordBits;
    localparam int NormVecBits  = 3 * NormBits;
    localparam int DiffBits     = CoordBits + 1;
    localparam int ProdBits     = 2 * DiffBits;
    localparam int TermBits     = NormBits + DiffBits;
    localparam int SumBits      = TermBits + 2;
    localparam int CrossBits    = ProdBits + 1;
    localparam int DividendBits = SumBits + 2;
    localparam int DenBits      = NormBits + 1;
    localparam int HiBits       = DividendBits - CoordBits;
    localparam int GeomStages   = 5;

    localparam logic [CoordBits-1:0] OneFixed  = CoordBits'(1 << FracBits);
    localparam logic [CoordBits-1:0] MaxPos    = CoordBits'((1 << (CoordBits - 1)) - 1);
    localparam logic [CoordBits-1:0] MinNegMag = CoordBits'(1 << (CoordBits - 1));

    typedef enum logic [1:0] {
        OP_ALONG_Z = 2'd0,
        OP_ALONG_X = 2'd1,
        OP_ALONG_Y = 2'd2,
        OP_UNUSED  = 2'd3
    } rti_op_t;

    typedef struct packed {
        logic [1:0]                  operation;
        logic [VecBits-1:0]          vertex_zero;
        logic [VecBits-1:0]          vertex_one;
        logic [VecBits-1:0]          vertex_two;
        logic [NormVecBits-1:0]      face_normal;
        logic signed [CoordBits-1:0] line_first;
        logic signed [CoordBits-1:0] line_second;
    } rti_req_t;

    // One item as it walks through the restoring divider.
    typedef struct packed {
        logic                 hit;
        logic                 neg;
        logic                 ovf;
        logic [DenBits-1:0]   rem;
        logic [DenBits-1:0]   den;
        logic [CoordBits-1:0] num_low;
        logic [CoordBits-1:0] quo;
    } rti_div_t;

endpackage
`default_nettype wire

### rtl/core/rti_in_if.sv
// Input channel of the intersection core: valid/ready plus one triangle test request.
// Depends on rti_pkg.
`default_nettype none
interface rti_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           operation;
    logic [rti_pkg::VecBits-1:0]          vertex_zero;
    logic [rti_pkg::VecBits-1:0]          vertex_one;
    logic [rti_pkg::VecBits-1:0]          vertex_two;
    logic [rti_pkg::NormVecBits-1:0]      face_normal;
    logic signed [rti_pkg::CoordBits-1:0] line_first;
    logic signed [rti_pkg::CoordBits-1:0] line_second;

    modport source (output valid, operation, vertex_zero, vertex_one, vertex_two,
                    face_normal, line_first, line_second, input ready);
    modport sink   (input valid, operation, vertex_zero, vertex_one, vertex_two,
                    face_normal, line_first, line_second, output ready);
endinterface
`default_nettype wire

### rtl/core/rti_out_if.sv
// Output channel of the intersection core: valid/ready plus hit flag and coordinate.
// Depends on rti_pkg.
`default_nettype none
interface rti_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [rti_pkg::CoordBits-1:0] cross_coord;

    modport source (output valid, hit, cross_coord, input ready);
    modport sink   (input valid, hit, cross_coord, output ready);
endinterface
`default_nettype wire

### rtl/core/rti_geom.sv
// Front pipeline: axis selection, edge products, inside test, numerator and divider setup.
// Depends on rti_pkg.
`default_nettype none
module rti_geom (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rti_pkg::rti_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rti_pkg::rti_div_t      out_data
);
    import rti_pkg::*;

    logic [GeomStages-1:0] vld_reg;
    logic [GeomStages-1:0] rdy;

    always_comb
    begin
        rdy[GeomStages-1] = !vld_reg[GeomStages-1] || out_ready;
        for (int k = 0; k < GeomStages - 1; k++)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[GeomStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < GeomStages; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage 0: pick the projected coordinates and form edge and point differences.
    logic signed [CoordBits-1:0] va [3];
    logic signed [CoordBits-1:0] vb [3];
    logic signed [CoordBits-1:0] vc0;
    logic signed [NormBits-1:0]  na, nb, nc;
    logic signed [NormBits-1:0]  nx, ny, nz;
    logic [VecBits-1:0]          vtx [3];
    logic                        bad_op;

    assign vtx[0] = in_data.vertex_zero;
    assign vtx[1] = in_data.vertex_one;
    assign vtx[2] = in_data.vertex_two;
    assign nx = in_data.face_normal[0*NormBits +: NormBits];
    assign ny = in_data.face_normal[1*NormBits +: NormBits];
    assign nz = in_data.face_normal[2*NormBits +: NormBits];

    always_comb
    begin
        bad_op = 1'b0;
        case (in_data.operation)
            OP_ALONG_Z:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    va[i] = vtx[i][0*CoordBits +: CoordBits];
                    vb[i] = vtx[i][1*CoordBits +: CoordBits];
                end
                vc0 = vtx[0][2*CoordBits +: CoordBits];
                na = nx; nb = ny; nc = nz;
            end
            OP_ALONG_X:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    va[i] = vtx[i][1*CoordBits +: CoordBits];
                    vb[i] = vtx[i][2*CoordBits +: CoordBits];
                end
                vc0 = vtx[0][0*CoordBits +: CoordBits];
                na = ny; nb = nz; nc = nx;
            end
            OP_ALONG_Y:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    va[i] = vtx[i][2*CoordBits +: CoordBits];
                    vb[i] = vtx[i][0*CoordBits +: CoordBits];
                end
                vc0 = vtx[0][1*CoordBits +: CoordBits];
                na = nz; nb = nx; nc = ny;
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    va[i] = '0;
                    vb[i] = '0;
                end
                vc0 = '0;
                na = '0; nb = '0; nc = '0;
                bad_op = 1'b1;
            end
        endcase
    end

    logic signed [DiffBits-1:0] ex_reg [3];
    logic signed [DiffBits-1:0] ey_reg [3];
    logic signed [DiffBits-1:0] px_reg [3];
    logic signed [DiffBits-1:0] py_reg [3];
    logic signed [DiffBits-1:0] da_reg, db_reg;
    logic signed [NormBits-1:0] na0_reg, nb0_reg, nc0_reg;
    logic signed [CoordBits-1:0] vc0_reg;
    logic                       miss0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ex_reg[i] <= DiffBits'(va[(i+1)%3]) - DiffBits'(va[i]);
                ey_reg[i] <= DiffBits'(vb[(i+1)%3]) - DiffBits'(vb[i]);
                px_reg[i] <= DiffBits'(in_data.line_first) - DiffBits'(va[i]);
                py_reg[i] <= DiffBits'(in_data.line_second) - DiffBits'(vb[i]);
            end
            da_reg    <= DiffBits'(va[0]) - DiffBits'(in_data.line_first);
            db_reg    <= DiffBits'(vb[0]) - DiffBits'(in_data.line_second);
            na0_reg   <= na;
            nb0_reg   <= nb;
            nc0_reg   <= nc;
            vc0_reg   <= vc0;
            miss0_reg <= bad_op || (nc == '0);
        end
    end

    // Stage 1: all products, one multiplier each.
    logic signed [ProdBits-1:0] pa_reg [3];
    logic signed [ProdBits-1:0] pb_reg [3];
    logic signed [TermBits-1:0] ta_reg, tb_reg;
    logic signed [2*NormBits-1:0] tc_reg;
    logic signed [NormBits-1:0] nc1_reg;
    logic                       miss1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1] && vld_reg[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= ProdBits'(ex_reg[i]) * ProdBits'(py_reg[i]);
                pb_reg[i] <= ProdBits'(ey_reg[i]) * ProdBits'(px_reg[i]);
            end
            ta_reg    <= TermBits'(na0_reg) * TermBits'(da_reg);
            tb_reg    <= TermBits'(nb0_reg) * TermBits'(db_reg);
            tc_reg    <= (2*NormBits)'(nc0_reg) * (2*NormBits)'(vc0_reg);
            nc1_reg   <= nc0_reg;
            miss1_reg <= miss0_reg;
        end
    end

    // Stage 2: cross products, inside test and plane numerator.
    logic signed [CrossBits-1:0] cr [3];
    logic                        all_ge, all_le, pt_inside;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cr[i] = CrossBits'(pa_reg[i]) - CrossBits'(pb_reg[i]);
        all_ge = !cr[0][CrossBits-1] && !cr[1][CrossBits-1] && !cr[2][CrossBits-1];
        all_le = (cr[0] <= 0) && (cr[1] <= 0) && (cr[2] <= 0);
        pt_inside = nc1_reg[NormBits-1] ? all_le : all_ge;
    end

    logic signed [SumBits-1:0]  num_reg;
    logic signed [NormBits-1:0] nc2_reg;
    logic                       hit2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2] && vld_reg[1])
        begin
            num_reg  <= SumBits'(ta_reg) + SumBits'(tb_reg) + SumBits'(tc_reg);
            nc2_reg  <= nc1_reg;
            hit2_reg <= !miss1_reg && pt_inside;
        end
    end

    // Stage 3: magnitudes and quotient sign.
    logic [SumBits-1:0]  un_reg;
    logic [NormBits-1:0] ud_reg;
    logic                neg_reg;
    logic                hit3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3] && vld_reg[2])
        begin
            un_reg   <= num_reg[SumBits-1] ? SumBits'(-num_reg) : SumBits'(num_reg);
            ud_reg   <= nc2_reg[NormBits-1] ? NormBits'(-nc2_reg) : NormBits'(nc2_reg);
            neg_reg  <= num_reg[SumBits-1] != nc2_reg[NormBits-1];
            hit3_reg <= hit2_reg;
        end
    end

    // Stage 4: rounded dividend 2|num|+|n| over 2|n|, overflow check of the top part.
    logic [DividendBits-1:0] dvd;
    logic [DenBits-1:0]      den;
    logic [HiBits-1:0]       hi;

    assign dvd = (DividendBits'(un_reg) << 1) + DividendBits'(ud_reg);
    assign den = {ud_reg, 1'b0};
    assign hi  = dvd[DividendBits-1:CoordBits];

    always_ff @(posedge clk)
    begin
        if (rdy[4] && vld_reg[3])
        begin
            out_data.hit     <= hit3_reg;
            out_data.neg     <= neg_reg;
            out_data.ovf     <= hi >= HiBits'(den);
            out_data.rem     <= hi[DenBits-1:0];
            out_data.den     <= den;
            out_data.num_low <= dvd[CoordBits-1:0];
            out_data.quo     <= '0;
        end
    end

endmodule
`default_nettype wire

### rtl/core/rti_div_step.sv
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on rti_pkg.
`default_nettype none
module rti_div_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rti_pkg::rti_div_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rti_pkg::rti_div_t      out_data
);
    import rti_pkg::*;

    logic             vld_reg;
    logic [DenBits:0] trial;
    logic [DenBits:0] diff;
    logic             take;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;

    assign trial = {in_data.rem, in_data.num_low[CoordBits-1]};
    assign diff  = trial - {1'b0, in_data.den};
    assign take  = trial >= {1'b0, in_data.den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_data.hit     <= in_data.hit;
            out_data.neg     <= in_data.neg;
            out_data.ovf     <= in_data.ovf;
            out_data.den     <= in_data.den;
            out_data.rem     <= take ? diff[DenBits-1:0] : trial[DenBits-1:0];
            out_data.num_low <= in_data.num_low << 1;
            out_data.quo     <= {in_data.quo[CoordBits-2:0], take};
        end
    end

endmodule
`default_nettype wire

### rtl/core/axis_ray_triangle_intersect_core.sv
// Top level of the axis-aligned ray/triangle intersection core.
// Depends on rti_pkg, rti_in_if, rti_out_if, rti_geom and rti_div_step.
//
//   Channel  | Modport | Payload                                        | Dir
//   ---------+---------+------------------------------------------------+----
//   in_ch    | sink    | operation, vertex_zero/one/two, face_normal,   | in
//            |         | line_first, line_second                        |
//   out_ch   | source  | hit, cross_coord                               | out
//
// Every item passes from input transfer to output valid through five geometry
// stages, one restoring divider stage per quotient bit, and the output register.
// One item is accepted per cycle unless a stall at the output has filled the chain.
// Reset clears only the valid bits of the stages; payload registers are not reset.
// Each stage holds when the stage after it is full and stalled, so a stall at the
// output fills bubbles first and loses or repeats nothing.
`default_nettype none
module axis_ray_triangle_intersect_core (
    input  wire logic clk,
    input  wire logic rst_n,
    rti_in_if.sink    in_ch,
    rti_out_if.source out_ch
);
    import rti_pkg::*;

    rti_req_t req;

    assign req.operation   = in_ch.operation;
    assign req.vertex_zero = in_ch.vertex_zero;
    assign req.vertex_one  = in_ch.vertex_one;
    assign req.vertex_two  = in_ch.vertex_two;
    assign req.face_normal = in_ch.face_normal;
    assign req.line_first  = in_ch.line_first;
    assign req.line_second = in_ch.line_second;

    // Chain of divider steps; index 0 is the geometry front output.
    rti_div_t div_data [CoordBits+1];
    logic     div_vld  [CoordBits+1];
    logic     div_rdy  [CoordBits+1];

    rti_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (req),
        .out_valid (div_vld[0]),
        .out_ready (div_rdy[0]),
        .out_data  (div_data[0])
    );

    for (genvar g = 0; g < CoordBits; g++)
    begin : g_div
        rti_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_vld[g]),
            .in_ready  (div_rdy[g]),
            .in_data   (div_data[g]),
            .out_valid (div_vld[g+1]),
            .out_ready (div_rdy[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // Output register: saturate the magnitude, apply the sign, replace misses by 1.0.
    rti_div_t            fin;
    logic [CoordBits-1:0] coord_next;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [CoordBits-1:0] coord_reg;
    logic                 out_free;

    assign fin      = div_data[CoordBits];
    assign out_free = !out_valid_reg || out_ch.ready;
    assign div_rdy[CoordBits] = out_free;

    always_comb
    begin
        if (!fin.hit)
            coord_next = OneFixed;
        else if (fin.neg)
            coord_next = (fin.ovf || fin.quo > MinNegMag) ? MinNegMag : CoordBits'(-fin.quo);
        else
            coord_next = (fin.ovf || fin.quo > MaxPos) ? MaxPos : fin.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= div_vld[CoordBits];
    end

    always_ff @(posedge clk)
    begin
        if (out_free && div_vld[CoordBits])
        begin
            hit_reg   <= fin.hit;
            coord_reg <= coord_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.hit         = hit_reg;
    assign out_ch.cross_coord = coord_reg;

    // A miss always reports 1.0.
    a_miss_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> coord_reg == OneFixed)
        else $error("miss reported with a coordinate other than 1.0");

    // With the output side ready, the whole ready chain must be open.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready |-> in_ch.ready)
        else $error("input stalled although the output is ready");

    // A held result must not vanish before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(coord_reg))
        else $error("stalled result lost");

endmodule
`default_nettype wire
